>>> sv/toel_pkg.sv
// shared types and constants for the timestamp ordered entry list
`timescale 1ns / 1ps
package toel_pkg;
    localparam int CAPACITY  = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 38;
    localparam int ENTRY_W   = 54;

    // item modes
    localparam logic [2:0] MODE_FRONT  = 3'd0;
    localparam logic [2:0] MODE_SORTED = 3'd1;
    localparam logic [2:0] MODE_APPEND = 3'd2;
    localparam logic [2:0] MODE_DEL_1ST = 3'd3;
    localparam logic [2:0] MODE_DEL_KEY = 3'd4;
    localparam logic [2:0] MODE_DEL_END = 3'd5;
    localparam logic [2:0] MODE_DUMP   = 3'd6;

    // result status codes
    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_NOMATCH = 3'd3;
    localparam logic [2:0] ST_READOUT = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic                load;    // capture the incoming transaction
        logic                insert;  // shift up from position and write entry
        logic                remove;  // shift down from position
        logic                front;   // position is zero
        logic                at_end;  // position is the count (insert) or count-1 (remove)
        logic                rd_step; // advance the readout pointer
        logic                rd_clr;  // restart the readout pointer
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0]    count;
        logic                found;   // an entry with equal key exists
        logic                rd_last; // readout pointer is at the final entry
    } t_sts;
endpackage

>>> sv/toel_datapath.sv
// entry cell chain with shift insert, shift delete and readout pointer
`timescale 1ns / 1ps
module toel_datapath import toel_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [2:0]           i_mode,
    input  logic [ENTRY_W-1:0]   i_entry,
    output t_sts                 o_sts,
    output logic [ENTRY_W-1:0]   o_rd_entry
);
    logic [ENTRY_W-1:0] r_cell [CAPACITY];
    logic [CNT_W-1:0]   r_count;
    logic [ENTRY_W-1:0] r_entry;
    logic [2:0]         r_mode;
    logic [IDX_W-1:0]   r_rd;
    logic [CAPACITY-1:0] w_lt, w_eq, w_used;
    logic [CNT_W-1:0]   w_pos;
    logic               w_found;

    // per cell key compares, only cells below the count take part
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            w_used[k] = CNT_W'(k) < r_count;
            w_lt[k] = w_used[k] && (r_cell[k][ENTRY_W-1 -: KEY_W] < r_entry[ENTRY_W-1 -: KEY_W]);
            w_eq[k] = w_used[k] && (r_cell[k][ENTRY_W-1 -: KEY_W] == r_entry[ENTRY_W-1 -: KEY_W]);
        end
    end

    // position: sorted = first entry not earlier (else the count), match = first equal entry
    always_comb begin
        w_pos   = '0;
        w_found = 1'b0;
        if (r_mode == MODE_DEL_KEY) begin
            for (int k = CAPACITY - 1; k >= 0; k--)
                if (w_eq[k]) begin
                    w_pos   = CNT_W'(k);
                    w_found = 1'b1;
                end
        end else begin
            w_pos = r_count;
            for (int k = CAPACITY - 1; k >= 0; k--)
                if (w_used[k] && !w_lt[k])
                    w_pos = CNT_W'(k);
        end
        if (i_cmd.front)
            w_pos = '0;
        else if (i_cmd.at_end)
            w_pos = i_cmd.insert ? r_count : r_count - CNT_W'(1);
    end

    // captured transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_entry <= i_entry;
            r_mode  <= i_mode;
        end
    end

    // cell chain: every cell picks itself, its lower or its upper neighbour, or the new entry
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CAPACITY; k++) begin
            if (i_cmd.insert) begin
                if (CNT_W'(k) == w_pos)
                    r_cell[k] <= r_entry;
                else if (CNT_W'(k) > w_pos && k > 0)
                    r_cell[k] <= r_cell[(k > 0) ? k - 1 : 0];
            end else if (i_cmd.remove) begin
                if (CNT_W'(k) >= w_pos && k < CAPACITY - 1)
                    r_cell[k] <= r_cell[(k < CAPACITY - 1) ? k + 1 : k];
            end
        end
    end

    // entry count and readout pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rd    <= '0;
        end else begin
            if (i_cmd.insert)
                r_count <= r_count + CNT_W'(1);
            else if (i_cmd.remove)
                r_count <= r_count - CNT_W'(1);
            if (i_cmd.rd_clr)
                r_rd <= '0;
            else if (i_cmd.rd_step)
                r_rd <= r_rd + IDX_W'(1);
        end
    end

    assign o_sts.count   = r_count;
    assign o_sts.found   = w_found;
    assign o_sts.rd_last = (CNT_W'(r_rd) + CNT_W'(1)) == r_count;
    assign o_rd_entry    = r_cell[r_rd];
endmodule

>>> sv/toel_ctrl.sv
// controller sequencing updates, readout and the result register
`timescale 1ns / 1ps
module toel_ctrl import toel_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_mode,
    input  t_sts               i_sts,
    input  logic [ENTRY_W-1:0] i_rd_entry,
    output t_cmd               o_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic [5:0]         o_count,
    output logic [ENTRY_W-1:0] o_entry,
    output logic               o_last
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [2:0]         r_mode;
    logic               r_valid;
    logic [2:0]         r_status;
    logic [ENTRY_W-1:0] r_entry;
    logic               r_last;
    logic               w_slot, w_full, w_empty;
    logic [CNT_W-1:0]   w_cnt_after;

    assign w_slot  = !r_valid || i_ready;
    assign w_full  = i_sts.count >= CNT_W'(CAPACITY);
    assign w_empty = i_sts.count == '0;
    assign o_ready = (r_state == S_IDLE);

    // commands
    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_state == S_IDLE) && i_valid;
        if (r_state == S_EXEC && w_slot) begin
            unique case (r_mode) inside
                MODE_FRONT, MODE_SORTED, MODE_APPEND: begin
                    o_cmd.insert = !w_full;
                    o_cmd.front  = (r_mode == MODE_FRONT);
                    o_cmd.at_end = (r_mode == MODE_APPEND);
                end
                MODE_DEL_1ST, MODE_DEL_END: begin
                    o_cmd.remove = !w_empty;
                    o_cmd.front  = (r_mode == MODE_DEL_1ST);
                    o_cmd.at_end = (r_mode == MODE_DEL_END);
                end
                MODE_DEL_KEY: o_cmd.remove = i_sts.found;
                default: o_cmd.rd_clr = 1'b1;
            endcase
        end
        if (r_state == S_DUMP && w_slot)
            o_cmd.rd_step = 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_EXEC;
            S_EXEC: if (w_slot)
                n_state = (r_mode == MODE_DUMP && !w_empty) ? S_DUMP : S_WAIT;
            S_DUMP: if (w_slot && i_sts.rd_last) n_state = S_WAIT;
            S_WAIT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign w_cnt_after = o_cmd.insert ? i_sts.count + CNT_W'(1) :
                         o_cmd.remove ? i_sts.count - CNT_W'(1) : i_sts.count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) r_mode <= i_mode;
            // result register
            if (r_state == S_EXEC && w_slot && !(r_mode == MODE_DUMP && !w_empty)) begin
                r_valid <= 1'b1;
                r_entry <= '0;
                r_last  <= 1'b1;
                o_count <= w_cnt_after[5:0];
                case (r_mode) inside
                    MODE_FRONT, MODE_SORTED, MODE_APPEND:
                        r_status <= w_full ? ST_FULL : ST_DONE;
                    MODE_DEL_1ST, MODE_DEL_END, MODE_DUMP:
                        r_status <= w_empty ? ST_EMPTY : ST_DONE;
                    MODE_DEL_KEY:
                        r_status <= w_empty ? ST_EMPTY : (i_sts.found ? ST_DONE : ST_NOMATCH);
                    default: r_status <= ST_DONE;
                endcase
            end else if (r_state == S_DUMP && w_slot) begin
                r_valid  <= 1'b1;
                r_status <= ST_READOUT;
                r_entry  <= i_rd_entry;
                r_last   <= i_sts.rd_last;
                o_count  <= i_sts.count[5:0];
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_entry  = r_entry;
    assign o_last   = r_last;
endmodule

>>> sv/timestamp_ordered_entry_list.sv
// top level of the timestamp ordered entry list
`timescale 1ns / 1ps
// Ordered list of up to 32 timestamped temperature entries held in a chain of
// cells that shift together. An update is carried out in the EXEC state, which
// puts its result in the output register once that register is free; the
// controller then passes through WAIT to IDLE, the only state that takes input,
// so a new transaction waits until the last is through. A readout of n entries
// clears the pointer in EXEC, then gives one result per cycle from DUMP while
// the output register is free, with last set on the final one. A result that
// waits for the output side holds the sequence until it is taken.
module timestamp_ordered_entry_list import toel_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_mode,
    input  logic [11:0]        i_year,
    input  logic [3:0]         i_month,
    input  logic [4:0]         i_day,
    input  logic [4:0]         i_hour,
    input  logic [5:0]         i_minute,
    input  logic [5:0]         i_second,
    input  logic signed [15:0] i_temperature,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic [5:0]         o_count,
    output logic [11:0]        o_out_year,
    output logic [3:0]         o_out_month,
    output logic [4:0]         o_out_day,
    output logic [4:0]         o_out_hour,
    output logic [5:0]         o_out_minute,
    output logic [5:0]         o_out_second,
    output logic signed [15:0] o_out_temperature,
    output logic               o_last
);
    t_cmd               w_cmd;
    t_sts               w_sts;
    logic [ENTRY_W-1:0] w_rd_entry, w_out_entry;

    toel_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_mode,
        .i_entry({i_year, i_month, i_day, i_hour, i_minute, i_second, i_temperature}),
        .o_sts(w_sts), .o_rd_entry(w_rd_entry)
    );

    toel_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_mode, .i_sts(w_sts),
        .i_rd_entry(w_rd_entry), .o_cmd(w_cmd), .o_valid, .i_ready,
        .o_status, .o_count, .o_entry(w_out_entry), .o_last
    );

    assign {o_out_year, o_out_month, o_out_day, o_out_hour, o_out_minute,
            o_out_second, o_out_temperature} = w_out_entry;
endmodule
